// ===== hw/rtl/byte_dma_engine_with_logic_ops_core_defines.svh =====
// assertion macros shared by the byte dma engine rtl
`ifndef BYTE_DMA_ENGINE_WITH_LOGIC_OPS_CORE_DEFINES_SVH
`define BYTE_DMA_ENGINE_WITH_LOGIC_OPS_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, held off during reset
`define BDMA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bdma assertion failed");

// next-cycle implication
`define BDMA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bdma assertion failed");

`endif

// ===== hw/rtl/bdma_pkg.sv =====
// types, codes and helpers for the byte dma engine
package bdma_pkg;

    // request types on the input channel
    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_READ     = 2'd1;
    localparam logic [1:0] REQ_MEM_DATA = 2'd2;

    // register indexes
    localparam logic [2:0] REG_PTR_LO  = 3'd0;
    localparam logic [2:0] REG_PTR_HI  = 3'd1;
    localparam logic [2:0] REG_BANK_LO = 3'd2;
    localparam logic [2:0] REG_BANK_HI = 3'd3;
    localparam logic [2:0] REG_CNT_LO  = 3'd4;
    localparam logic [2:0] REG_CNT_HI  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_REG_DATA  = 2'd0;
    localparam logic [1:0] KIND_MEM_READ  = 2'd1;
    localparam logic [1:0] KIND_MEM_WRITE = 2'd2;

    // configuration registers
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE  = 2'd2;

    // pointer modes
    localparam logic [1:0] MODE_CONTINUE = 2'd0;
    localparam logic [1:0] MODE_RELOAD   = 2'd1;

    // combine operations
    localparam logic [1:0] OP_COPY = 2'd0;
    localparam logic [1:0] OP_XOR  = 2'd1;
    localparam logic [1:0] OP_OR   = 2'd2;
    localparam logic [1:0] OP_AND  = 2'd3;

    localparam logic [15:0] PTR_HIGH_BIT = 16'h8000;

    // result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] bank;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        done;
        logic        last;
    } t_result;

    function automatic logic [15:0] fn_advance(input logic [15:0] ptr, input logic [1:0] mode);
        logic [15:0] stepped;
        stepped = (ptr + 16'd1) | PTR_HIGH_BIT;
        if (mode == MODE_CONTINUE || mode == MODE_RELOAD) begin
            return stepped;
        end
        return ptr;
    endfunction

endpackage

// ===== hw/rtl/bdma_res_fifo.sv =====
// result queue: takes up to two beats per cycle, hands out one
module bdma_res_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push0,
    input  logic                         i_push1,
    input  bdma_pkg::t_result            i_data0,
    input  bdma_pkg::t_result            i_data1,
    input  logic                         i_pop,
    output logic                         o_valid,
    output bdma_pkg::t_result            o_data,
    output logic [bdma_pkg::CNT_W-1:0]   o_count
);

    bdma_pkg::t_result              r_mem [bdma_pkg::FIFO_DEPTH];
    logic [bdma_pkg::PTR_W-1:0]     r_wr;
    logic [bdma_pkg::PTR_W-1:0]     r_rd;
    logic [bdma_pkg::CNT_W-1:0]     r_count;
    logic [bdma_pkg::PTR_W-1:0]     n_wr;
    logic [bdma_pkg::PTR_W-1:0]     n_rd;
    logic [bdma_pkg::CNT_W-1:0]     n_count;
    logic [bdma_pkg::PTR_W-1:0]     w_wr_next;

    assign w_wr_next = r_wr + bdma_pkg::PTR_W'(1);

    always_comb begin
        n_wr    = r_wr + bdma_pkg::PTR_W'(i_push0) + bdma_pkg::PTR_W'(i_push1);
        n_rd    = r_rd + bdma_pkg::PTR_W'(i_pop);
        n_count = r_count + bdma_pkg::CNT_W'(i_push0) + bdma_pkg::CNT_W'(i_push1)
                  - bdma_pkg::CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[w_wr_next] <= i_data1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

// ===== hw/rtl/byte_dma_engine_with_logic_ops_core.sv =====
// Byte DMA engine top level. One beat is taken per cycle on the input channel unless it is
// stalled: it lands in an input register and is decoded from there once the queue has room,
// which updates the pointer, bank and count state and pushes its results (none, one or two)
// into a four-entry result queue. The queue drains one beat per cycle while the output is not
// stalled, so an input beat that causes two results (a write request followed by the next
// source read request) takes two output beats, and the input side stalls only while the queue
// holds more than two beats. Configuration writes take effect at the next clock edge.
`include "byte_dma_engine_with_logic_ops_core_defines.svh"

module byte_dma_engine_with_logic_ops_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bdma_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bdma_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [2:0]                          i_reg_index,
    input  logic                                i_side_select,
    input  logic [7:0]                          i_write_byte,
    input  logic [7:0]                          i_memory_byte,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_result_kind,
    output logic [15:0]                         o_mem_bank,
    output logic [15:0]                         o_mem_address,
    output logic [7:0]                          o_data_byte,
    output logic                                o_transfer_done,
    output logic                                o_last_of_run
);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_WAIT_SRC = 2'd1,
        PH_WAIT_DST = 2'd2
    } t_phase;

    // configuration registers
    logic [1:0]  r_src_mode;
    logic [1:0]  r_dst_mode;
    logic [1:0]  r_op;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_type;
    logic [2:0]  r_idx;
    logic        r_side;
    logic [7:0]  r_wb;
    logic [7:0]  r_mb;

    // engine state
    logic [15:0] r_src_ptr,  n_src_ptr;
    logic [15:0] r_dst_ptr,  n_dst_ptr;
    logic [15:0] r_src_bank, n_src_bank;
    logic [15:0] r_dst_bank, n_dst_bank;
    logic [15:0] r_count,    n_count;
    logic [16:0] r_remain,   n_remain;
    logic [15:0] r_save_src, n_save_src;
    logic [15:0] r_save_dst, n_save_dst;
    logic [7:0]  r_held,     n_held;
    t_phase      r_phase,    n_phase;

    logic                           w_in_accept;
    logic                           w_proc;
    logic                           w_push0;
    logic                           w_push1;
    logic                           w_pop;
    bdma_pkg::t_result              w_res0;
    bdma_pkg::t_result              w_res1;
    bdma_pkg::t_result              w_head;
    logic                           w_fifo_valid;
    logic [bdma_pkg::CNT_W-1:0]     w_fifo_count;
    logic [15:0]                    w_ptr_sel;
    logic [15:0]                    w_bank_sel;
    logic [7:0]                     w_rd_byte;
    logic [7:0]                     w_comb;
    logic [15:0]                    w_src_adv;
    logic [15:0]                    w_dst_adv;
    logic [16:0]                    w_remain_dec;

    // room for two results keeps a two-beat item from overrunning the queue
    assign w_proc      = r_in_valid && (w_fifo_count <= bdma_pkg::CNT_W'(bdma_pkg::FIFO_DEPTH - 2));
    assign o_in_stall  = r_in_valid && !w_proc;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_mode <= bdma_pkg::MODE_CONTINUE;
            r_dst_mode <= bdma_pkg::MODE_CONTINUE;
            r_op       <= bdma_pkg::OP_COPY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bdma_pkg::CFG_SRC_MODE: r_src_mode <= i_cfg_data;
                bdma_pkg::CFG_DST_MODE: r_dst_mode <= i_cfg_data;
                bdma_pkg::CFG_COMBINE:  r_op       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_type <= i_req_type;
            r_idx  <= i_reg_index;
            r_side <= i_side_select;
            r_wb   <= i_write_byte;
            r_mb   <= i_memory_byte;
        end
    end

    assign w_ptr_sel    = r_side ? r_dst_ptr : r_src_ptr;
    assign w_bank_sel   = r_side ? r_dst_bank : r_src_bank;
    assign w_src_adv    = bdma_pkg::fn_advance(r_src_ptr, r_src_mode);
    assign w_dst_adv    = bdma_pkg::fn_advance(r_dst_ptr, r_dst_mode);
    assign w_remain_dec = r_remain - 17'd1;

    always_comb begin
        case (r_idx)
            bdma_pkg::REG_PTR_LO:  w_rd_byte = w_ptr_sel[7:0];
            bdma_pkg::REG_PTR_HI:  w_rd_byte = w_ptr_sel[15:8];
            bdma_pkg::REG_BANK_LO: w_rd_byte = w_bank_sel[7:0];
            bdma_pkg::REG_BANK_HI: w_rd_byte = w_bank_sel[15:8];
            bdma_pkg::REG_CNT_LO:  w_rd_byte = r_count[7:0];
            bdma_pkg::REG_CNT_HI:  w_rd_byte = r_count[15:8];
            default:               w_rd_byte = 8'd0;
        endcase
    end

    always_comb begin
        case (r_op)
            bdma_pkg::OP_COPY: w_comb = r_held;
            bdma_pkg::OP_XOR:  w_comb = r_held ^ r_mb;
            bdma_pkg::OP_OR:   w_comb = r_held | r_mb;
            bdma_pkg::OP_AND:  w_comb = r_held & r_mb;
            default:           w_comb = r_held;
        endcase
    end

    always_comb begin
        n_src_ptr  = r_src_ptr;
        n_dst_ptr  = r_dst_ptr;
        n_src_bank = r_src_bank;
        n_dst_bank = r_dst_bank;
        n_count    = r_count;
        n_remain   = r_remain;
        n_save_src = r_save_src;
        n_save_dst = r_save_dst;
        n_held     = r_held;
        n_phase    = r_phase;
        w_push0    = 1'b0;
        w_push1    = 1'b0;
        w_res0     = '0;
        w_res1     = '0;
        if (w_proc) begin
            case (r_type)
                bdma_pkg::REQ_READ: begin
                    w_push0      = 1'b1;
                    w_res0.kind  = bdma_pkg::KIND_REG_DATA;
                    w_res0.data  = w_rd_byte;
                    w_res0.last  = 1'b1;
                end
                bdma_pkg::REQ_WRITE: begin
                    if (r_phase == PH_IDLE) begin
                        case (r_idx)
                            bdma_pkg::REG_PTR_LO: begin
                                if (r_side) n_dst_ptr[7:0] = r_wb;
                                else        n_src_ptr[7:0] = r_wb;
                            end
                            bdma_pkg::REG_PTR_HI: begin
                                if (r_side) n_dst_ptr[15:8] = r_wb | 8'h80;
                                else        n_src_ptr[15:8] = r_wb | 8'h80;
                            end
                            bdma_pkg::REG_BANK_LO: begin
                                if (r_side) n_dst_bank[7:0] = r_wb;
                                else        n_src_bank[7:0] = r_wb;
                            end
                            bdma_pkg::REG_BANK_HI: begin
                                if (r_side) n_dst_bank[15:8] = r_wb;
                                else        n_src_bank[15:8] = r_wb;
                            end
                            bdma_pkg::REG_CNT_LO: begin
                                n_count[7:0] = r_wb;
                            end
                            bdma_pkg::REG_CNT_HI: begin
                                // start of a run: first source read goes out at once
                                n_count[15:8] = r_wb;
                                n_remain      = {1'b0, r_wb, r_count[7:0]} + 17'd1;
                                n_save_src    = r_src_ptr;
                                n_save_dst    = r_dst_ptr;
                                n_phase       = PH_WAIT_SRC;
                                w_push0       = 1'b1;
                                w_res0.kind   = bdma_pkg::KIND_MEM_READ;
                                w_res0.bank   = r_src_bank;
                                w_res0.addr   = r_src_ptr;
                                w_res0.last   = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                bdma_pkg::REQ_MEM_DATA: begin
                    case (r_phase)
                        PH_WAIT_SRC: begin
                            n_held      = r_mb;
                            n_phase     = PH_WAIT_DST;
                            w_push0     = 1'b1;
                            w_res0.kind = bdma_pkg::KIND_MEM_READ;
                            w_res0.bank = r_dst_bank;
                            w_res0.addr = r_dst_ptr;
                            w_res0.last = 1'b1;
                        end
                        PH_WAIT_DST: begin
                            n_src_ptr   = w_src_adv;
                            n_dst_ptr   = w_dst_adv;
                            n_remain    = w_remain_dec;
                            w_push0     = 1'b1;
                            w_res0.kind = bdma_pkg::KIND_MEM_WRITE;
                            w_res0.bank = r_dst_bank;
                            w_res0.addr = r_dst_ptr;
                            w_res0.data = w_comb;
                            if (w_remain_dec == '0) begin
                                // end of run: reload-mode pointers go back to their start
                                if (r_src_mode == bdma_pkg::MODE_RELOAD) n_src_ptr = r_save_src;
                                if (r_dst_mode == bdma_pkg::MODE_RELOAD) n_dst_ptr = r_save_dst;
                                n_phase     = PH_IDLE;
                                w_res0.done = 1'b1;
                                w_res0.last = 1'b1;
                            end else begin
                                n_phase     = PH_WAIT_SRC;
                                w_push1     = 1'b1;
                                w_res1.kind = bdma_pkg::KIND_MEM_READ;
                                w_res1.bank = r_src_bank;
                                w_res1.addr = w_src_adv;
                                w_res1.last = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_ptr  <= '0;
            r_dst_ptr  <= '0;
            r_src_bank <= '0;
            r_dst_bank <= '0;
            r_count    <= '0;
            r_remain   <= '0;
            r_save_src <= '0;
            r_save_dst <= '0;
            r_held     <= '0;
            r_phase    <= PH_IDLE;
        end else begin
            r_src_ptr  <= n_src_ptr;
            r_dst_ptr  <= n_dst_ptr;
            r_src_bank <= n_src_bank;
            r_dst_bank <= n_dst_bank;
            r_count    <= n_count;
            r_remain   <= n_remain;
            r_save_src <= n_save_src;
            r_save_dst <= n_save_dst;
            r_held     <= n_held;
            r_phase    <= n_phase;
        end
    end

    assign w_pop = w_fifo_valid && !i_out_stall;

    bdma_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_push0),
        .i_push1 (w_push1),
        .i_data0 (w_res0),
        .i_data1 (w_res1),
        .i_pop   (w_pop),
        .o_valid (w_fifo_valid),
        .o_data  (w_head),
        .o_count (w_fifo_count)
    );

    assign o_out_valid     = w_fifo_valid;
    assign o_result_kind   = w_head.kind;
    assign o_mem_bank      = w_head.bank;
    assign o_mem_address   = w_head.addr;
    assign o_data_byte     = w_head.data;
    assign o_transfer_done = w_head.done;
    assign o_last_of_run   = w_head.last;

    `BDMA_ASSERT_IMP(a_queue_bound, 1'b1, w_fifo_count <= bdma_pkg::CNT_W'(bdma_pkg::FIFO_DEPTH))
    `BDMA_ASSERT_IMP(a_idle_no_remain, r_phase == PH_IDLE, r_remain == '0)
    `BDMA_ASSERT_NEXT(a_run_start,
        w_proc && r_type == bdma_pkg::REQ_WRITE && r_idx == bdma_pkg::REG_CNT_HI && r_phase == PH_IDLE,
        r_phase == PH_WAIT_SRC && r_remain != '0)
    `BDMA_ASSERT_NEXT(a_run_end,
        w_proc && r_type == bdma_pkg::REQ_MEM_DATA && r_phase == PH_WAIT_DST && r_remain == 17'd1,
        r_phase == PH_IDLE)

endmodule
